// ===== sv/kruf_pkg.sv =====
// Shared widths, limits and sequencer codes for the Kruskal union-find edge filter.
package kruf_pkg;

  localparam int unsigned VID_W    = 10;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned COST_W   = 32;
  localparam int unsigned SIZE_W   = 11;
  localparam int unsigned COUNT_W  = 10;

  localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;
  localparam logic [VID_W-1:0]   VCOUNT_RESET = 10'd1023;

  // Sequencer codes
  localparam int unsigned ST_W = 3;
  localparam logic [ST_W-1:0] ST_IDLE   = 3'd0;
  localparam logic [ST_W-1:0] ST_WALK_A = 3'd1;
  localparam logic [ST_W-1:0] ST_WALK_B = 3'd2;
  localparam logic [ST_W-1:0] ST_LINK   = 3'd3;
  localparam logic [ST_W-1:0] ST_CLEAR  = 3'd4;

endpackage

// ===== sv/kruskal_union_find_edge_accept.sv =====
// Kruskal edge filter: union by size over a disjoint-set forest held in one memory.
//
// Usage: raise start_i with action_i, end_a_i, end_b_i and weight_i while busy_o
// is low; the beat is taken at that clock edge. Exactly one result per beat comes
// back on done_o for one cycle with accepted_o, bad_vertex_o, total_cost_o,
// tree_edges_o and spanning_done_o. The receiver cannot stall; the result is
// simply there for that one cycle, and a new beat may be started in that cycle.
// Edges must be offered in ascending weight order.
// A bad endpoint gives its result in the cycle after the beat. A good edge walks
// from each endpoint up to its root, one read of the forest memory per step, as
// deep as that endpoint lies in its tree (at most log2 of the set size under
// union by size); it then reports when the roots match, or links the two roots
// and reports when it is accepted. A clear action sweeps the memory, one entry a
// cycle, and then reports. After reset the same sweep runs with busy_o high and
// no result. The vertex_count register is written over the cfg channel (always
// ready); write it only while the block is idle.
module kruskal_union_find_edge_accept
  import kruf_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // edge command channel
  input  logic                start_i,
  output logic                busy_o,
  input  logic                action_i,
  input  logic [VID_W-1:0]    end_a_i,
  input  logic [VID_W-1:0]    end_b_i,
  input  logic [WEIGHT_W-1:0] weight_i,
  // result channel
  output logic                done_o,
  output logic                accepted_o,
  output logic                bad_vertex_o,
  output logic [COST_W-1:0]   total_cost_o,
  output logic [COUNT_W-1:0]  tree_edges_o,
  output logic                spanning_done_o,
  // configuration channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [VID_W-1:0]    cfg_data_i
);

  localparam int unsigned AW     = $clog2(MAX_VERTICES);
  localparam int unsigned WORD_W = SIZE_W + AW;
  localparam logic [AW-1:0] LAST_IDX = AW'(MAX_VERTICES - 1);
  localparam logic [SIZE_W-1:0] SIZE_ONE = SIZE_W'(1);

  // Forest memory: each word is {set size, parent link}
  logic [WORD_W-1:0] mem_q [MAX_VERTICES];
  logic [WORD_W-1:0] rd_data_q;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [AW-1:0]     rd_addr;

  logic [ST_W-1:0]     state_q, state_d;
  logic [AW-1:0]       walk_q, walk_d;
  logic [AW-1:0]       b_q, b_d;
  logic [WEIGHT_W-1:0] w_q, w_d;
  logic [AW-1:0]       root_a_q, root_a_d;
  logic [SIZE_W-1:0]   size_a_q, size_a_d;
  logic [AW-1:0]       root_b_q, root_b_d;
  logic [SIZE_W-1:0]   size_b_q, size_b_d;
  logic                a_big_q, a_big_d;
  logic [AW-1:0]       clr_idx_q, clr_idx_d;
  logic                report_q, report_d;
  logic [COST_W-1:0]   cost_q, cost_d;
  logic [COUNT_W-1:0]  count_q, count_d;
  logic [VID_W-1:0]    vcount_q;
  logic                done_q, done_d;
  logic                acc_q, acc_d;
  logic                bad_q, bad_d;

  logic [AW-1:0]     rd_parent;
  logic [SIZE_W-1:0] rd_size;
  logic              rd_is_root;
  logic              a_ok, b_ok;
  logic [COST_W:0]   cost_sum;

  assign rd_parent  = rd_data_q[AW-1:0];
  assign rd_size    = rd_data_q[WORD_W-1:AW];
  assign rd_is_root = (rd_parent == walk_q);

  // Endpoint range checks
  assign a_ok = (end_a_i != '0) && (end_a_i <= vcount_q) && (32'(end_a_i) < MAX_VERTICES);
  assign b_ok = (end_b_i != '0) && (end_b_i <= vcount_q) && (32'(end_b_i) < MAX_VERTICES);

  assign cost_sum = {1'b0, cost_q} + {{(COST_W + 1 - WEIGHT_W){1'b0}}, w_q};

  // Memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    walk_d    = walk_q;
    b_d       = b_q;
    w_d       = w_q;
    root_a_d  = root_a_q;
    size_a_d  = size_a_q;
    root_b_d  = root_b_q;
    size_b_d  = size_b_q;
    a_big_d   = a_big_q;
    clr_idx_d = clr_idx_q;
    report_d  = report_q;
    cost_d    = cost_q;
    count_d   = count_q;
    done_d    = 1'b0;
    acc_d     = acc_q;
    bad_d     = bad_q;
    mem_we    = 1'b0;
    mem_waddr = clr_idx_q;
    mem_wdata = {SIZE_ONE, clr_idx_q};
    rd_addr   = rd_parent;

    unique case (state_q)
      ST_IDLE: begin
        rd_addr = AW'(end_a_i);
        if (start_i) begin
          b_d    = AW'(end_b_i);
          w_d    = weight_i;
          walk_d = AW'(end_a_i);
          if (action_i) begin
            // clear forest and totals, then report
            cost_d    = '0;
            count_d   = '0;
            clr_idx_d = '0;
            report_d  = 1'b1;
            state_d   = ST_CLEAR;
          end else if (!a_ok || !b_ok) begin
            // drop the edge, report at once
            done_d = 1'b1;
            acc_d  = 1'b0;
            bad_d  = 1'b1;
          end else begin
            state_d = ST_WALK_A;
          end
        end
      end

      ST_WALK_A: begin
        if (rd_is_root) begin
          root_a_d = walk_q;
          size_a_d = rd_size;
          rd_addr  = b_q;
          walk_d   = b_q;
          state_d  = ST_WALK_B;
        end else begin
          walk_d = rd_parent;
        end
      end

      ST_WALK_B: begin
        if (rd_is_root) begin
          root_b_d = walk_q;
          size_b_d = rd_size;
          if (walk_q == root_a_q) begin
            // same component: no change
            done_d  = 1'b1;
            acc_d   = 1'b0;
            bad_d   = 1'b0;
            state_d = ST_IDLE;
          end else begin
            // link the smaller root under the larger, ties under end_a's root
            mem_we = 1'b1;
            if (size_a_q >= rd_size) begin
              a_big_d   = 1'b1;
              mem_waddr = walk_q;
              mem_wdata = {rd_size, root_a_q};
            end else begin
              a_big_d   = 1'b0;
              mem_waddr = root_a_q;
              mem_wdata = {size_a_q, walk_q};
            end
            state_d = ST_LINK;
          end
        end else begin
          walk_d = rd_parent;
        end
      end

      ST_LINK: begin
        // grow the surviving root and advance the totals
        mem_we = 1'b1;
        if (a_big_q) begin
          mem_waddr = root_a_q;
          mem_wdata = {size_a_q + size_b_q, root_a_q};
        end else begin
          mem_waddr = root_b_q;
          mem_wdata = {size_b_q + size_a_q, root_b_q};
        end
        cost_d  = cost_sum[COST_W] ? '1 : cost_sum[COST_W-1:0];
        count_d = (count_q == COUNT_MAX) ? count_q : count_q + COUNT_W'(1);
        done_d  = 1'b1;
        acc_d   = 1'b1;
        bad_d   = 1'b0;
        state_d = ST_IDLE;
      end

      ST_CLEAR: begin
        // sweep every entry back to a singleton root
        mem_we    = 1'b1;
        mem_waddr = clr_idx_q;
        mem_wdata = {SIZE_ONE, clr_idx_q};
        clr_idx_d = clr_idx_q + AW'(1);
        if (clr_idx_q == LAST_IDX) begin
          done_d   = report_q;
          acc_d    = 1'b0;
          bad_d    = 1'b0;
          report_d = 1'b0;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_idx_q <= '0;
      report_q  <= 1'b0;
      cost_q    <= '0;
      count_q   <= '0;
      done_q    <= 1'b0;
      vcount_q  <= VCOUNT_RESET;
    end else begin
      state_q   <= state_d;
      clr_idx_q <= clr_idx_d;
      report_q  <= report_d;
      cost_q    <= cost_d;
      count_q   <= count_d;
      done_q    <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        vcount_q <= cfg_data_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    walk_q   <= walk_d;
    b_q      <= b_d;
    w_q      <= w_d;
    root_a_q <= root_a_d;
    size_a_q <= size_a_d;
    root_b_q <= root_b_d;
    size_b_q <= size_b_d;
    a_big_q  <= a_big_d;
    acc_q    <= acc_d;
    bad_q    <= bad_d;
  end

  assign busy_o          = (state_q != ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign done_o          = done_q;
  assign accepted_o      = acc_q;
  assign bad_vertex_o    = bad_q;
  assign total_cost_o    = cost_q;
  assign tree_edges_o    = count_q;
  assign spanning_done_o = (vcount_q != '0) && (count_q == vcount_q - VID_W'(1));

endmodule

// ===== test/kruf_edge_monitor.sv =====
// Edge-filter monitor: command codes, a forest predictor and the result comparison.
`timescale 1ns / 100ps

package kruf_act_pkg;
  typedef enum logic {
    ACT_EDGE  = 1'b0,
    ACT_CLEAR = 1'b1
  } edge_act_e;
endpackage

module kruf_edge_monitor
  import kruf_pkg::*;
  import kruf_act_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  logic                action_i,
  input  logic [VID_W-1:0]    end_a_i,
  input  logic [VID_W-1:0]    end_b_i,
  input  logic [WEIGHT_W-1:0] weight_i,
  input  logic                done_i,
  input  logic                accepted_i,
  input  logic                bad_vertex_i,
  input  logic [COST_W-1:0]   total_cost_i,
  input  logic [COUNT_W-1:0]  tree_edges_i,
  input  logic                spanning_done_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [VID_W-1:0]    cfg_data_i,
  output int unsigned         mismatches_o,
  output int unsigned         pending_o,
  output int unsigned         joins_o,
  output int unsigned         bad_flags_o,
  output int unsigned         spans_o
);

  typedef struct packed {
    logic               accepted;
    logic               bad;
    logic [COST_W-1:0]  cost;
    logic [COUNT_W-1:0] edges;
    logic               spanned;
  } verdict_t;

  // Predicted forest, totals and register
  logic [SIZE_W-1:0]  parent_q [MAX_VERTICES];
  logic [SIZE_W-1:0]  size_q   [MAX_VERTICES];
  logic [COST_W-1:0]  cost_q;
  logic [COUNT_W-1:0] joined_q;
  logic [VID_W-1:0]   vcount_q;

  verdict_t edge_verdicts [$];

  function automatic void wipe_forest();
    for (int unsigned v = 0; v < MAX_VERTICES; v++) begin
      parent_q[v] = SIZE_W'(v);
      size_q[v]   = SIZE_W'(1);
    end
    cost_q   = '0;
    joined_q = '0;
  endfunction

  // Append one prediction at the tail of the outstanding list
  function automatic void enqueue_verdict(verdict_t vd);
    edge_verdicts = {edge_verdicts, vd};
  endfunction

  function automatic bit vertex_in_use(logic [VID_W-1:0] v);
    return (v != '0) && (v <= vcount_q) && (int'(v) < MAX_VERTICES);
  endfunction

  // Walk parent links up to the root, bounded by MAX_VERTICES steps
  function automatic int unsigned root_of(int unsigned v);
    int unsigned p;
    for (int unsigned n = 0; n < MAX_VERTICES; n++) begin
      p = parent_q[v];
      if (p == v || p >= MAX_VERTICES) break;
      v = p;
    end
    return v;
  endfunction

  // Apply one command beat to the predicted forest and report its totals
  function automatic verdict_t judge_edge(edge_act_e act, logic [VID_W-1:0] a,
                                          logic [VID_W-1:0] b, logic [WEIGHT_W-1:0] w);
    verdict_t    vd;
    int unsigned ra;
    int unsigned rb;
    logic [COST_W:0] sum;
    vd = '0;
    if (act == ACT_CLEAR) begin
      wipe_forest();
    end else if (!vertex_in_use(a) || !vertex_in_use(b)) begin
      vd.bad = 1'b1;
    end else begin
      ra = root_of(a);
      rb = root_of(b);
      if (ra != rb) begin
        // smaller set goes under the larger; on a tie end_b's root goes under
        if (size_q[ra] >= size_q[rb]) begin
          parent_q[rb] = SIZE_W'(ra);
          size_q[ra]   = size_q[ra] + size_q[rb];
        end else begin
          parent_q[ra] = SIZE_W'(rb);
          size_q[rb]   = size_q[rb] + size_q[ra];
        end
        sum    = {1'b0, cost_q} + w;
        cost_q = sum[COST_W] ? '1 : sum[COST_W-1:0];
        if (joined_q != COUNT_MAX) joined_q = joined_q + 1'b1;
        vd.accepted = 1'b1;
      end
    end
    vd.cost    = cost_q;
    vd.edges   = joined_q;
    vd.spanned = (vcount_q != '0) && (joined_q == vcount_q - 1'b1);
    return vd;
  endfunction

  verdict_t got;
  verdict_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wipe_forest();
      vcount_q = VCOUNT_RESET;
      edge_verdicts.delete();
      pending_o = 0;
    end else begin
      // compare the result beat with the oldest prediction
      if (done_i !== 1'b0) begin
        got = '{accepted_i, bad_vertex_i, total_cost_i, tree_edges_i, spanning_done_i};
        if (edge_verdicts.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= 10)
            $display("%0t: result beat with nothing outstanding: %s",
                     $realtime,
                     $sformatf("acc=%b bad=%b cost=%0d edges=%0d span=%b",
                               got.accepted, got.bad, got.cost, got.edges,
                               got.spanned));
        end else begin
          want = edge_verdicts.pop_front();
          if (got !== want) begin
            mismatches_o++;
            if (mismatches_o <= 10)
              $display("%0t: mismatch: expected %s, got %s", $realtime,
                       $sformatf("acc=%b bad=%b cost=%0d edges=%0d span=%b",
                                 want.accepted, want.bad, want.cost, want.edges,
                                 want.spanned),
                       $sformatf("acc=%b bad=%b cost=%0d edges=%0d span=%b",
                                 got.accepted, got.bad, got.cost, got.edges,
                                 got.spanned));
          end
          if (want.accepted) joins_o++;
          if (want.bad) bad_flags_o++;
          if (want.spanned) spans_o++;
        end
      end
      // track register writes
      if (cfg_valid_i && cfg_ready_i) vcount_q = cfg_data_i;
      // predict each accepted command beat
      if (start_i && !busy_i)
        enqueue_verdict(judge_edge(edge_act_e'(action_i), end_a_i, end_b_i, weight_i));
      pending_o = edge_verdicts.size();
    end
  end

endmodule

// ===== test/tb_kruskal_union_find_edge_accept.sv =====
// Testbench top: clock, reset, command and register stimulus, and the final verdict.
`timescale 1ns / 100ps

module tb_kruskal_union_find_edge_accept;
  import kruf_pkg::*;
  import kruf_act_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600_000;
  localparam int unsigned ITEM_TARGET = 1400;
  localparam int unsigned TAIL_CYCLES = 64;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic                action_i;
  logic [VID_W-1:0]    end_a_i;
  logic [VID_W-1:0]    end_b_i;
  logic [WEIGHT_W-1:0] weight_i;
  logic                done_o;
  logic                accepted_o;
  logic                bad_vertex_o;
  logic [COST_W-1:0]   total_cost_o;
  logic [COUNT_W-1:0]  tree_edges_o;
  logic                spanning_done_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [VID_W-1:0]    cfg_data_i;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned joins;
  int unsigned bad_flags;
  int unsigned spans;

  int unsigned cycles;
  int unsigned idle_pct;
  int unsigned cmd_count;
  int unsigned clears_sent;
  int unsigned cfg_writes;
  int unsigned cur_vcount;

  kruskal_union_find_edge_accept dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .action_i        (action_i),
    .end_a_i         (end_a_i),
    .end_b_i         (end_b_i),
    .weight_i        (weight_i),
    .done_o          (done_o),
    .accepted_o      (accepted_o),
    .bad_vertex_o    (bad_vertex_o),
    .total_cost_o    (total_cost_o),
    .tree_edges_o    (tree_edges_o),
    .spanning_done_o (spanning_done_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  kruf_edge_monitor forest_watch (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_i          (busy_o),
    .action_i        (action_i),
    .end_a_i         (end_a_i),
    .end_b_i         (end_b_i),
    .weight_i        (weight_i),
    .done_i          (done_o),
    .accepted_i      (accepted_o),
    .bad_vertex_i    (bad_vertex_o),
    .total_cost_i    (total_cost_o),
    .tree_edges_i    (tree_edges_o),
    .spanning_done_i (spanning_done_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .mismatches_o    (mismatches),
    .pending_o       (pending),
    .joins_o         (joins),
    .bad_flags_o     (bad_flags),
    .spans_o         (spans)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Drop start and wait until every result is back and the block is free
  task automatic settle();
    start_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0 || busy_o) @(negedge clk_i);
  endtask

  task automatic write_vcount(input int unsigned n);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= VID_W'(n);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cur_vcount = n;
    cfg_writes++;
  endtask

  // Offer one command beat after a random gap and hold it until taken
  task automatic send_item(input edge_act_e act, input int unsigned a, input int unsigned b,
                           input int unsigned w);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i  <= 1'b1;
    action_i <= act;
    end_a_i  <= VID_W'(a);
    end_b_i  <= VID_W'(b);
    weight_i <= WEIGHT_W'(w);
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    @(negedge clk_i);
    if (act == ACT_CLEAR) begin
      clears_sent++;
      cmd_count++;
    end else if (a >= 1 && a <= cur_vcount && b >= 1 && b <= cur_vcount) begin
      cmd_count++;
    end
  endtask

  function automatic int unsigned next_weight(int unsigned w, int unsigned step_max);
    int unsigned nw;
    nw = w + $urandom_range(step_max, 0);
    return (nw > 65535) ? 65535 : nw;
  endfunction

  function automatic int unsigned stray_vertex(int unsigned n);
    case ($urandom_range(2, 0))
      0: begin
        return 0;
      end
      1: begin
        return (n < 1023) ? $urandom_range(1023, n + 1) : 0;
      end
      default: begin
        return $urandom_range(1023, 0);
      end
    endcase
  endfunction

  // One sequence: pick a vertex count, usually clear, then offer ascending edges
  task automatic run_round(input int unsigned rnd);
    int unsigned n;
    int unsigned len;
    int unsigned roll;
    int unsigned w;
    int unsigned step_max;
    int unsigned a;
    int unsigned b;
    bit          balanced;
    case (rnd % 3)
      0: begin
        idle_pct = 0;
      end
      1: begin
        idle_pct = 45;
      end
      default: begin
        idle_pct = 37;
      end
    endcase
    roll     = $urandom_range(99, 0);
    balanced = (roll < 15);
    if (balanced) n = 64;
    else if (roll < 25) n = 1023;
    else if (roll < 32) n = $urandom_range(1022, 41);
    else n = $urandom_range(40, 2);
    if (n != cur_vcount) write_vcount(n);
    if ($urandom_range(99, 0) < 80) send_item(ACT_CLEAR, $urandom_range(1023, 0),
                                              $urandom_range(1023, 0), $urandom_range(65535, 0));
    w = ($urandom_range(99, 0) < 20) ? $urandom_range(65535, 0) : $urandom_range(500, 0);
    case ($urandom_range(2, 0))
      0: begin
        step_max = 2;
      end
      1: begin
        step_max = 300;
      end
      default: begin
        step_max = 4000;
      end
    endcase
    // pair merges of doubling stride build the deepest trees union by size allows
    if (balanced) begin
      for (int unsigned s = 1; s < n; s *= 2) begin
        for (int unsigned v = 1; v + s <= n; v += 2 * s) begin
          w = next_weight(w, step_max);
          if ($urandom_range(1, 0)) send_item(ACT_EDGE, v + s, v, w);
          else send_item(ACT_EDGE, v, v + s, w);
        end
      end
    end
    len = (n <= 40) ? ((3 * n < 20) ? 20 : 3 * n) : (balanced ? 20 : 60);
    for (int unsigned i = 0; i < len; i++) begin
      w    = next_weight(w, step_max);
      a    = $urandom_range(n, 1);
      b    = $urandom_range(n, 1);
      roll = $urandom_range(99, 0);
      if (roll < 3) a = stray_vertex(n);
      else if (roll < 6) b = stray_vertex(n);
      if (roll == 99) send_item(ACT_CLEAR, a, b, w);
      else send_item(ACT_EDGE, a, b, w);
    end
  endtask

  initial begin
    int unsigned rnd;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    action_i    = 1'b0;
    end_a_i     = '0;
    end_b_i     = '0;
    weight_i    = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    idle_pct    = 0;
    cur_vcount  = VCOUNT_RESET;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Four vertices: bad ids, self loops, tie merges, a spanning tree, a clear
    write_vcount(4);
    send_item(ACT_EDGE, 0, 1, 0);
    send_item(ACT_EDGE, 1, 5, 0);
    send_item(ACT_EDGE, 1023, 1023, 65535);
    send_item(ACT_EDGE, 1, 1, 0);
    send_item(ACT_EDGE, 1, 2, 0);
    send_item(ACT_EDGE, 3, 4, 7);
    send_item(ACT_EDGE, 1, 3, 7);
    send_item(ACT_EDGE, 2, 4, 100);
    send_item(ACT_EDGE, 4, 4, 100);
    send_item(ACT_EDGE, 4, 1, 65535);
    send_item(ACT_CLEAR, 1023, 1023, 65535);
    // A lone vertex spans at once; zero vertices flag every edge
    write_vcount(1);
    send_item(ACT_EDGE, 1, 1, 0);
    send_item(ACT_EDGE, 1, 2, 0);
    write_vcount(0);
    send_item(ACT_EDGE, 1, 1, 0);
    send_item(ACT_CLEAR, 0, 0, 0);
    // Full range with alternating id bit patterns
    write_vcount(1023);
    send_item(ACT_EDGE, 682, 341, 65535);
    send_item(ACT_EDGE, 1023, 1, 65535);
    send_item(ACT_EDGE, 341, 1023, 65535);
    send_item(ACT_EDGE, 682, 1, 65535);

    rnd = 0;
    while (cmd_count < ITEM_TARGET) begin
      run_round(rnd);
      rnd++;
    end

    // Drain, then watch a while for stray result beats
    settle();
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("Covered %0d commands (%0d clears) across %0d vertex-count writes in %0d cycles.",
             cmd_count, clears_sent, cfg_writes, cycles);
    $display("Saw %0d tree edges joined, %0d bad-endpoint flags, %0d spanning reports.",
             joins, bad_flags, spans);
    if (mismatches == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
